>>> sv/bbe_pkg.sv
// Shared types, constants and the reciprocal table of the 3x3 box blur.
// Used by bbe_avg, box_blur_3x3_edge_aware and the testbench; depends on nothing.
package bbe_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CFG_W = 11;
    localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd480;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int CH_W      = 8;
    localparam int RGB_W     = 3 * CH_W;
    localparam int SUM_W     = 12;
    localparam int NUM_W     = SUM_W + 1;
    localparam int CNT_W     = 4;
    localparam int RECIP_W   = 20;
    localparam int PROD_W    = NUM_W + RECIP_W;
    localparam int DIV_SHIFT = 20;
    localparam int POS_W     = 10;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_rgb;

    typedef struct packed {
        logic [2:0] rsel;
        logic [2:0] csel;
    } t_avg_sel;

    // ceil(2^DIV_SHIFT / (2*count)); exact floor for every numerator below 8192
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd6:    m = 20'd87382;
            4'd9:    m = 20'd58255;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

>>> sv/bbe_ram.sv
// Line store: simple dual-port synchronous RAM, one write and one registered read.
// Depends on nothing.
module bbe_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bbe_avg.sv
// Masked 3x3 sum and rounded average, two pipeline stages (sum, multiply).
// Depends on bbe_pkg.
module bbe_avg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  bbe_pkg::t_rgb      i_grid [9],
    input  bbe_pkg::t_avg_sel  i_sel,
    output logic               o_valid,
    output bbe_pkg::t_rgb      o_rgb
);

    logic [bbe_pkg::SUM_W-1:0]  sum_r, sum_g, sum_b;
    logic [1:0]                 nr, nc;
    logic [bbe_pkg::CNT_W-1:0]  cnt;

    logic                        r_v1, r_v2;
    logic [bbe_pkg::NUM_W-1:0]   r_num [3];
    logic [bbe_pkg::CNT_W-1:0]   r_cnt;
    logic [bbe_pkg::PROD_W-1:0]  r_prod [3];

    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
                if (i_sel.rsel[k] && i_sel.csel[m]) begin
                    sum_r = sum_r + bbe_pkg::SUM_W'(i_grid[k*3+m].red);
                    sum_g = sum_g + bbe_pkg::SUM_W'(i_grid[k*3+m].green);
                    sum_b = sum_b + bbe_pkg::SUM_W'(i_grid[k*3+m].blue);
                end
            end
        end
        nr  = 2'($countones(i_sel.rsel));
        nc  = 2'($countones(i_sel.csel));
        cnt = bbe_pkg::CNT_W'(nr) * bbe_pkg::CNT_W'(nc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num[0] <= {sum_r, 1'b0} + bbe_pkg::NUM_W'(cnt);
        r_num[1] <= {sum_g, 1'b0} + bbe_pkg::NUM_W'(cnt);
        r_num[2] <= {sum_b, 1'b0} + bbe_pkg::NUM_W'(cnt);
        r_cnt    <= cnt;
        for (int ch = 0; ch < 3; ch++) begin
            r_prod[ch] <= bbe_pkg::PROD_W'(r_num[ch]) *
                          bbe_pkg::PROD_W'(bbe_pkg::recip(r_cnt));
        end
    end

    assign o_valid     = r_v2;
    assign o_rgb.red   = r_prod[0][bbe_pkg::DIV_SHIFT +: bbe_pkg::CH_W];
    assign o_rgb.green = r_prod[1][bbe_pkg::DIV_SHIFT +: bbe_pkg::CH_W];
    assign o_rgb.blue  = r_prod[2][bbe_pkg::DIV_SHIFT +: bbe_pkg::CH_W];

endmodule

>>> sv/box_blur_3x3_edge_aware.sv
// Top level of the edge-aware 3x3 box blur: sequencer, window, config port.
// Depends on bbe_pkg, bbe_ram (two line stores) and bbe_avg.
//
//  channel   dir  handshake                    payload
//  s_axis    in   tvalid/tready                tdata: red, green, blue
//  m_axis    out  tvalid/tready                tdata: rgb, row, col; tlast; tuser
//  apb       in   psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// A pixel is taken in idle and its line-store read completes in the read state; then
// each of its n = 0..4 results is launched and passes the sum/multiply pipeline.
// A one-beat output register parts the result side; a stalled m_axis holds the
// next launch. Reset is synchronous; the line stores are not cleared, edge
// masking keeps unwritten entries out of every result.
module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH  = bbe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bbe_pkg::DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] in_red, [15:8] in_green, [23:16] in_blue
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // red, green, blue, out_row[33:24], out_col[43:34]
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser,   // [0] end_of_frame
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > bbe_pkg::CFG_W) ?
                        $clog2(MAX_WIDTH + 1) : bbe_pkg::CFG_W;
    localparam int HW = ($clog2(MAX_HEIGHT + 1) > bbe_pkg::CFG_W) ?
                        $clog2(MAX_HEIGHT + 1) : bbe_pkg::CFG_W;
    localparam logic [2:0] SEL_ALL  = 3'b111;
    localparam logic [2:0] SEL_NEAR = 3'b110;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_EMIT, S_WAIT} t_state;

    t_state                      r_state;
    logic [bbe_pkg::CFG_W-1:0]   r_cfg_w, r_cfg_h;
    logic [CW-1:0]               r_col, r_c, r_tcol;
    logic [RW-1:0]               r_row, r_r, r_trow;
    bbe_pkg::t_rgb               r_pix;
    bbe_pkg::t_rgb               r_cur [3];
    bbe_pkg::t_rgb               r_prv [3];
    bbe_pkg::t_rgb               r_grid [9];
    logic [2:0]                  r_rv, r_cv;
    logic [3:0]                  r_pend;
    logic [1:0]                  r_idx;
    logic                        r_last;
    logic                        r_ov;
    logic [47:0]                 r_odata;
    logic                        r_olast, r_oeof;

    logic [WW-1:0]               w_ext, w_eff, w_last;
    logic [HW-1:0]               h_ext, h_eff, h_last;
    logic                        in_acc, cfg_wr, col_end, row_end;
    logic                        c_end, r_endrow;
    bbe_pkg::t_rgb               old_q, new_q;
    logic [bbe_pkg::RGB_W-1:0]   old_raw, new_raw;
    bbe_pkg::t_rgb               col2 [3];
    logic                        launch;
    logic [1:0]                  pick;
    logic [3:0]                  pend_left;
    logic                        ar, ac;
    bbe_pkg::t_avg_sel           sel;
    logic                        avg_valid;
    bbe_pkg::t_rgb               avg_rgb;
    logic [RW+9:0]               row_ext;
    logic [CW+9:0]               col_ext;

    assign w_ext  = WW'(r_cfg_w);
    assign h_ext  = HW'(r_cfg_h);
    assign w_eff  = (r_cfg_w == '0) ? WW'(1) :
                    (w_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_ext;
    assign h_eff  = (r_cfg_h == '0) ? HW'(1) :
                    (h_ext > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : h_ext;
    assign w_last = w_eff - WW'(1);
    assign h_last = h_eff - HW'(1);

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign col_end = (WW'(r_col) == w_last);
    assign row_end = (HW'(r_row) == h_last);
    assign c_end    = (WW'(r_c) == w_last);
    assign r_endrow = (HW'(r_r) == h_last);

    assign s_axis_tready = (r_state == S_IDLE);
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == bbe_pkg::REG_HEIGHT) ? 32'(r_cfg_h) : 32'(r_cfg_w);

    bbe_ram #(.DEPTH(MAX_WIDTH), .WIDTH(bbe_pkg::RGB_W)) u_older (
        .i_clk   (i_clk),
        .i_we    (r_state == S_READ),
        .i_waddr (r_c),
        .i_wdata (new_raw),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (old_raw)
    );

    bbe_ram #(.DEPTH(MAX_WIDTH), .WIDTH(bbe_pkg::RGB_W)) u_newer (
        .i_clk   (i_clk),
        .i_we    (r_state == S_READ),
        .i_waddr (r_c),
        .i_wdata (r_pix),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (new_raw)
    );

    assign old_q   = bbe_pkg::t_rgb'(old_raw);
    assign new_q   = bbe_pkg::t_rgb'(new_raw);
    assign col2[0] = old_q;
    assign col2[1] = new_q;
    assign col2[2] = r_pix;

    always_comb begin
        if (r_pend[0]) begin
            pick = 2'd0;
        end else if (r_pend[1]) begin
            pick = 2'd1;
        end else if (r_pend[2]) begin
            pick = 2'd2;
        end else begin
            pick = 2'd3;
        end
        pend_left       = r_pend;
        pend_left[pick] = 1'b0;
        ar       = !pick[1];
        ac       = !pick[0];
        sel.rsel = r_rv & (ar ? SEL_ALL : SEL_NEAR);
        sel.csel = r_cv & (ac ? SEL_ALL : SEL_NEAR);
        launch   = (r_state == S_EMIT) && !r_ov && (r_pend != '0);
    end

    bbe_avg u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (launch),
        .i_grid  (r_grid),
        .i_sel   (sel),
        .o_valid (avg_valid),
        .o_rgb   (avg_rgb)
    );

    assign row_ext = (RW+10)'(r_trow);
    assign col_ext = (CW+10)'(r_tcol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg_w <= bbe_pkg::RST_WIDTH;
            r_cfg_h <= bbe_pkg::RST_HEIGHT;
            r_col   <= '0;
            r_row   <= '0;
            r_pend  <= '0;
            r_ov    <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_cur[k] <= '0;
                r_prv[k] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == bbe_pkg::REG_HEIGHT) begin
                    r_cfg_h <= pwdata[bbe_pkg::CFG_W-1:0];
                end else begin
                    r_cfg_w <= pwdata[bbe_pkg::CFG_W-1:0];
                end
                r_col <= '0;
                r_row <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_cur[k] <= '0;
                    r_prv[k] <= '0;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pix.red   <= s_axis_tdata[7:0];
                        r_pix.green <= s_axis_tdata[15:8];
                        r_pix.blue  <= s_axis_tdata[23:16];
                        r_c   <= r_col;
                        r_r   <= r_row;
                        r_col <= col_end ? '0 : r_col + CW'(1);
                        if (col_end) begin
                            r_row <= row_end ? '0 : r_row + RW'(1);
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    for (int k = 0; k < 3; k++) begin
                        r_grid[k*3]   <= r_prv[k];
                        r_grid[k*3+1] <= r_cur[k];
                        r_grid[k*3+2] <= col2[k];
                        r_prv[k]      <= r_cur[k];
                        r_cur[k]      <= col2[k];
                    end
                    r_rv <= {1'b1, r_r != '0, r_r > RW'(1)};
                    r_cv <= {1'b1, r_c != '0, r_c > CW'(1)};
                    r_pend[0] <= (r_r != '0) && (r_c != '0);
                    r_pend[1] <= (r_r != '0) && c_end;
                    r_pend[2] <= r_endrow && (r_c != '0);
                    r_pend[3] <= r_endrow && c_end;
                    if (((r_r != '0) || r_endrow) && ((r_c != '0) || c_end)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (launch) begin
                        r_pend  <= pend_left;
                        r_idx   <= pick;
                        r_last  <= (pend_left == '0);
                        r_trow  <= r_r - RW'(ar);
                        r_tcol  <= r_c - CW'(ac);
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (avg_valid) begin
                        r_ov    <= 1'b1;
                        r_odata <= {4'b0, col_ext[9:0], row_ext[9:0],
                                    avg_rgb.blue, avg_rgb.green, avg_rgb.red};
                        r_olast <= r_last;
                        r_oeof  <= (r_idx == 2'd3);
                        r_state <= r_last ? S_IDLE : S_EMIT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        m_axis_tvalid   = r_ov;
        m_axis_tdata    = r_odata;
        m_axis_tlast    = r_olast;
        m_axis_tuser[0] = r_oeof;
    end

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_pend == '0))
        else $error("results still pending while idle");

    a_avg_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        avg_valid |-> ((r_state == S_WAIT) && !r_ov))
        else $error("average arrived outside wait or over a full output register");

    a_launch_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        launch |-> ((sel.rsel != '0) && (sel.csel != '0)))
        else $error("empty neighbor mask at launch");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("end of frame without last of run");

    a_launch_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        launch |=> (r_state == S_WAIT) && !avg_valid)
        else $error("launch did not enter the averaging wait");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for box_blur_3x3_edge_aware: streams RGB frames of many sizes,
// predicts every blurred pixel in-line and compares each output beat field by field.
// Depends on bbe_pkg and the box_blur_3x3_edge_aware RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_DIM      = bbe_pkg::DEF_MAX_WIDTH;

    typedef struct {
        bbe_pkg::t_rgb rgb;
        logic [9:0]    row;
        logic [9:0]    col;
        logic          run_end;
        logic          frame_end;
    } blur_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [7:0] red, [15:8] green, [23:16] blue
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // [7:0] red, [15:8] green, [23:16] blue,
                                      // [33:24] row, [43:34] col, [47:44] zero
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;        // [0] end of frame
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    box_blur_3x3_edge_aware i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // blur predictor state
    bbe_pkg::t_rgb line_older [MAX_DIM];
    bbe_pkg::t_rgb line_newer [MAX_DIM];
    bbe_pkg::t_rgb win_near [3];
    bbe_pkg::t_rgb win_far [3];
    bbe_pkg::t_rgb nbr [3][3];
    int            next_row;
    int            next_col;
    logic [10:0]   width_reg;
    logic [10:0]   height_reg;
    blur_result_t  blurred_expected[$];

    int mismatches = 0;
    int pixels_sent = 0;
    int results_checked = 0;
    int size_settings = 0;
    int stall_pct = 0;
    int gap_max = 0;
    int burst_left = 1;
    int hold_request = 0;
    int hold_left = 0;

    function automatic int clamp_dim(logic [10:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic bbe_pkg::t_rgb mk_rgb(int r, int g, int b);
        bbe_pkg::t_rgb p;
        p.red   = 8'(r);
        p.green = 8'(g);
        p.blue  = 8'(b);
        return p;
    endfunction

    function automatic void push_blurred(int r, int c, int rr, int cc, int w, int h);
        int unsigned  acc_r, acc_g, acc_b, cnt;
        int           fr, fc, k, m;
        blur_result_t res;
        acc_r = 0;
        acc_g = 0;
        acc_b = 0;
        cnt   = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                fr = r + dr;
                fc = c + dc;
                if (fr < 0 || fr >= h || fc < 0 || fc >= w) continue;
                k = fr - rr + 2;
                m = fc - cc + 2;
                if (k < 0 || k > 2 || m < 0 || m > 2) continue;
                acc_r += nbr[k][m].red;
                acc_g += nbr[k][m].green;
                acc_b += nbr[k][m].blue;
                cnt++;
            end
        end
        if (cnt == 0) cnt = 1;
        res.rgb.red   = 8'((2 * acc_r + cnt) / (2 * cnt));
        res.rgb.green = 8'((2 * acc_g + cnt) / (2 * cnt));
        res.rgb.blue  = 8'((2 * acc_b + cnt) / (2 * cnt));
        res.row       = 10'(r);
        res.col       = 10'(c);
        res.run_end   = 1'b0;
        res.frame_end = (r == h - 1 && c == w - 1);
        blurred_expected.push_back(res);
    endfunction

    function automatic void predict_pixel(bbe_pkg::t_rgb pix);
        int w, h, rr, cc, prior_count;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        if (next_row >= h) next_row = 0;
        if (next_col >= w) next_col = 0;
        rr = next_row;
        cc = next_col;
        for (int k = 0; k < 3; k++) begin
            nbr[k][0] = win_far[k];
            nbr[k][1] = win_near[k];
        end
        nbr[0][2] = line_older[cc];
        nbr[1][2] = line_newer[cc];
        nbr[2][2] = pix;
        prior_count = blurred_expected.size();
        if (rr >= 1 && cc >= 1) push_blurred(rr - 1, cc - 1, rr, cc, w, h);
        if (rr >= 1 && cc == w - 1) push_blurred(rr - 1, cc, rr, cc, w, h);
        if (rr == h - 1 && cc >= 1) push_blurred(rr, cc - 1, rr, cc, w, h);
        if (rr == h - 1 && cc == w - 1) push_blurred(rr, cc, rr, cc, w, h);
        if (blurred_expected.size() > prior_count)
            blurred_expected[blurred_expected.size() - 1].run_end = 1'b1;
        for (int k = 0; k < 3; k++) begin
            win_far[k]  = win_near[k];
            win_near[k] = nbr[k][2];
        end
        line_older[cc] = line_newer[cc];
        line_newer[cc] = pix;
        next_col = cc + 1;
        if (next_col >= w) begin
            next_col = 0;
            next_row = rr + 1;
            if (next_row >= h) next_row = 0;
        end
        pixels_sent++;
    endfunction

    function automatic void predict_config(logic idx, logic [10:0] v);
        if (idx == bbe_pkg::REG_WIDTH) width_reg = v;
        else height_reg = v;
        next_row = 0;
        next_col = 0;
        for (int k = 0; k < 3; k++) begin
            win_near[k] = '0;
            win_far[k]  = '0;
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input longint got, input longint want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    task automatic check_result_beat();
        blur_result_t  want;
        bbe_pkg::t_rgb got;
        if (blurred_expected.size() == 0) begin
            report_mismatch("beat with nothing pending", m_axis_tdata, 0);
        end else begin
            want = blurred_expected.pop_front();
            got  = bbe_pkg::t_rgb'(m_axis_tdata[23:0]);
            check_field("red", got.red, want.rgb.red);
            check_field("green", got.green, want.rgb.green);
            check_field("blue", got.blue, want.rgb.blue);
            check_field("row", m_axis_tdata[33:24], want.row);
            check_field("col", m_axis_tdata[43:34], want.col);
            check_field("tdata padding", m_axis_tdata[47:44], 0);
            check_field("tlast", m_axis_tlast, want.run_end);
            check_field("tuser end of frame", m_axis_tuser[0], want.frame_end);
            results_checked++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result_beat();
    end

    // receiver: random stalls, or a counted hold-off when requested
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_pixel(input bbe_pkg::t_rgb pix);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pixel(pix);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            if (gap_max > 0) begin
                gap = $urandom_range(1, gap_max);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (blurred_expected.size() != 0);
    endtask

    task automatic end_phase();
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [10:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {21'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        predict_config(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(input logic idx, input logic [10:0] want);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field(idx == bbe_pkg::REG_WIDTH ? "image_width readback" :
                    "image_height readback", prdata[10:0], want);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_size(input logic [10:0] w, input logic [10:0] h);
        apb_write(bbe_pkg::REG_WIDTH, w);
        apb_write(bbe_pkg::REG_HEIGHT, h);
        apb_read_check(bbe_pkg::REG_WIDTH, w);
        apb_read_check(bbe_pkg::REG_HEIGHT, h);
        size_settings++;
    endtask

    function automatic bbe_pkg::t_rgb random_pixel();
        bbe_pkg::t_rgb p;
        p = bbe_pkg::t_rgb'(24'($urandom));
        if ($urandom_range(7) == 0) p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
        if ($urandom_range(7) == 0) p.green = $urandom_range(1) ? 8'hFF : 8'h00;
        if ($urandom_range(7) == 0) p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
        return p;
    endfunction

    // 1x1 frames pass pixels through; zero sizes count as one
    task automatic test_unit_frames();
        stall_pct = 0;
        gap_max   = 0;
        apb_read_check(bbe_pkg::REG_WIDTH, bbe_pkg::RST_WIDTH);
        apb_read_check(bbe_pkg::REG_HEIGHT, bbe_pkg::RST_HEIGHT);
        set_size(11'd1, 11'd1);
        send_pixel(mk_rgb(0, 0, 0));
        send_pixel(mk_rgb(255, 255, 255));
        send_pixel(mk_rgb(255, 0, 170));
        end_phase();
        set_size(11'd0, 11'd0);
        send_pixel(mk_rgb(85, 255, 0));
        end_phase();
    endtask

    // quarter and half fractions on corner averages
    task automatic test_rounding();
        set_size(11'd2, 11'd2);
        send_pixel(mk_rgb(0, 1, 255));
        send_pixel(mk_rgb(0, 0, 255));
        send_pixel(mk_rgb(0, 0, 255));
        send_pixel(mk_rgb(2, 0, 254));
        end_phase();
    endtask

    task automatic test_full_window();
        stall_pct = 30;
        gap_max   = 3;
        set_size(11'd3, 11'd3);
        for (int i = 0; i < 9; i++)
            send_pixel(mk_rgb((i % 2) ? 255 : 0, i * 31, (i % 3 == 0) ? 255 : i));
        end_phase();
    endtask

    task automatic test_restart_mid_frame();
        set_size(11'd4, 11'd2);
        for (int i = 0; i < 6; i++) send_pixel(random_pixel());
        end_phase();
        apb_write(bbe_pkg::REG_HEIGHT, 11'd2);
        for (int i = 0; i < 5; i++) send_pixel(random_pixel());
        end_phase();
        apb_write(bbe_pkg::REG_WIDTH, 11'd4);
        for (int i = 0; i < 8; i++) send_pixel(random_pixel());
        end_phase();
    endtask

    task automatic test_random_frames();
        logic [10:0] w, h;
        int          ew, eh, total, start, room;
        start = pixels_sent;
        while (pixels_sent - start < 320) begin
            case ($urandom_range(9))
                0:       w = 11'd0;
                1:       w = 11'($urandom_range(13, 40));
                default: w = 11'($urandom_range(1, 10));
            endcase
            case ($urandom_range(9))
                0:       h = 11'd0;
                1:       h = 11'($urandom_range(9, 16));
                default: h = 11'($urandom_range(1, 8));
            endcase
            ew = clamp_dim(w);
            eh = clamp_dim(h);
            if (ew * eh > 100) begin
                h  = 11'((100 / ew > 0) ? 100 / ew : 1);
                eh = clamp_dim(h);
            end
            stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 60);
            gap_max   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
            set_size(w, h);
            total = ew * eh * $urandom_range(1, 2);
            if ($urandom_range(4) == 0) total = $urandom_range(1, ew * eh);
            room = 320 - (pixels_sent - start);
            if (total > room) total = room;
            for (int i = 0; i < total; i++) send_pixel(random_pixel());
            end_phase();
        end
    endtask

    // fill the block while the output is held off
    task automatic test_output_backpressure();
        stall_pct = 0;
        gap_max   = 0;
        set_size(11'd6, 11'd5);
        hold_request = 300;
        for (int i = 0; i < 30; i++) send_pixel(random_pixel());
        end_phase();
    endtask

    task automatic test_sender_pause();
        stall_pct = 25;
        gap_max   = 2;
        set_size(11'd5, 11'd4);
        for (int i = 0; i < 10; i++) send_pixel(random_pixel());
        hold_until_drained();
        for (int i = 0; i < 10; i++) send_pixel(random_pixel());
        end_phase();
    endtask

    // oversized settings clamp to the maximum frame size
    task automatic test_size_limits();
        stall_pct = 10;
        gap_max   = 0;
        set_size(11'h7FF, 11'd1);
        for (int i = 0; i < 24; i++) send_pixel(random_pixel());
        end_phase();
        set_size(11'd1, 11'd1024);
        for (int i = 0; i < 24; i++) send_pixel(random_pixel());
        end_phase();
    endtask

    initial begin
        for (int i = 0; i < MAX_DIM; i++) begin
            line_older[i] = '0;
            line_newer[i] = '0;
        end
        predict_config(bbe_pkg::REG_WIDTH, bbe_pkg::RST_WIDTH);
        predict_config(bbe_pkg::REG_HEIGHT, bbe_pkg::RST_HEIGHT);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unit_frames();
        test_rounding();
        test_full_window();
        test_restart_mid_frame();
        test_random_frames();
        test_output_backpressure();
        test_sender_pause();
        test_size_limits();

        $display("sent %0d pixels, checked %0d blurred pixels across %0d frame sizes",
                 pixels_sent, results_checked, size_settings);
        $display("sizes 1x1 up to clamped oversize settings, mid-frame restarts, stalls and gaps");
        if (mismatches == 0 && blurred_expected.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("run did not finish in time, %0d results pending", blurred_expected.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
sv/bbe_pkg.sv
sv/bbe_ram.sv
sv/bbe_avg.sv
sv/box_blur_3x3_edge_aware.sv
tb/sv/testbench.sv
